// ----- rtl/core/ffpa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffpa_pkg
// Types and constants shared by the first-fit page allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ffpa_pkg;

    localparam int FIELD_W   = 48;
    localparam int BS_W      = 17;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 4;
    localparam int ADDR_BITS = 48;
    localparam int SPACE_BITS = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;

    // largest address, one bit wider than a field so sums can be compared
    localparam logic [FIELD_W:0] SPACE_MAX =
        {{(FIELD_W + 1 - SPACE_BITS){1'b0}}, {SPACE_BITS{1'b1}}};

    // remainder unit: bits retired per cycle
    localparam int REM_STEP   = 4;
    localparam int REM_CYCLES = FIELD_W / REM_STEP;
    localparam int REM_CNT_W  = $clog2(REM_CYCLES + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = CFG_IDX_W'(1);

    localparam logic [STATUS_W-1:0] ST_REUSED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CUT       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FREED     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;

    typedef struct packed {
        logic               func;
        logic [FIELD_W-1:0] req_size;
        logic [FIELD_W-1:0] req_offset;
    } t_req;

    typedef struct packed {
        logic [FIELD_W-1:0]  page_offset;
        logic [FIELD_W-1:0]  page_size;
        logic [STATUS_W-1:0] status;
    } t_res;

    typedef struct packed {
        logic [FIELD_W-1:0] size;
        logic [FIELD_W-1:0] offset;
    } t_entry;

    typedef struct packed {
        logic                ld_req;
        logic                div_start;
        logic                calc_need;
        logic                idx_clr;
        logic                idx_inc;
        logic                rd_en;
        logic                push;
        logic                shift_wr;
        logic                cnt_dec;
        logic                cut;
        logic                emit;
        logic [STATUS_W-1:0] emit_status;
    } t_cmd;

    typedef struct packed {
        logic func;
        logic div_done;
        logic need_ovf;
        logic at_end;
        logic fit;
        logic full;
        logic end_ovf;
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/core/ffpa_rem.sv -----
// ----------------------------------------------------------------------------
// ffpa_rem
// Iterative remainder unit: restoring division, REM_STEP bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ffpa_rem
    import ffpa_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [FIELD_W-1:0] i_dividend,
    input  wire logic [BS_W-1:0]    i_divisor,
    output logic                    o_done,
    output logic [BS_W-1:0]         o_rem
);

    logic                 r_busy;
    logic                 r_done;
    logic [REM_CNT_W-1:0] r_cnt;
    logic [FIELD_W-1:0]   r_dvd;
    logic [BS_W-1:0]      r_rem;
    logic [BS_W-1:0]      r_div;
    logic [FIELD_W-1:0]   n_dvd;
    logic [BS_W-1:0]      n_rem;
    logic [BS_W:0]        cand;

    // partial remainder stays below the divisor; the shifted value needs one extra bit
    always_comb begin
        n_rem = r_rem;
        n_dvd = r_dvd;
        cand  = '0;
        for (int k = 0; k < REM_STEP; k++) begin
            cand  = {n_rem, n_dvd[FIELD_W-1]};
            n_rem = (cand >= {1'b0, r_div}) ? BS_W'(cand - {1'b0, r_div})
                                            : cand[BS_W-1:0];
            n_dvd = {n_dvd[FIELD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= REM_CNT_W'(REM_CYCLES);
            end else if (r_busy) begin
                r_cnt <= r_cnt - REM_CNT_W'(1);
                if (r_cnt == REM_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ----- rtl/core/ffpa_dp.sv -----
// ----------------------------------------------------------------------------
// ffpa_dp
// Datapath: config registers, size rounding, free-list memory, end pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module ffpa_dp
    import ffpa_pkg::*;
#(
    parameter int FREE_ENTRIES = 16
)
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [FIELD_W-1:0]   i_cfg_wdata,
    input  wire t_req                 i_req,
    input  wire t_cmd                 i_cmd,
    output t_sts                      o_sts,
    output t_res                      o_res,
    output logic                      o_res_strobe
);

    localparam int IDX_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(FREE_ENTRIES + 1);

    logic [BS_W-1:0]    r_block_size;
    logic [FIELD_W-1:0] r_end;
    t_req               r_req;
    logic [FIELD_W:0]   r_need;
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_cnt;
    t_entry             r_mem [FREE_ENTRIES];
    t_entry             r_rd;
    t_res               r_res;
    logic               r_strobe;

    logic [BS_W-1:0]    bs_eff;
    logic [BS_W-1:0]    rem;
    logic               rem_done;
    logic [BS_W-1:0]    pad;
    logic [FIELD_W:0]   end_sum;
    logic [CNT_W-1:0]   idx_m1;

    assign bs_eff  = (r_block_size == '0) ? BS_W'(1) : r_block_size;
    assign pad     = (rem != '0) ? (bs_eff - rem) : '0;
    assign end_sum = {1'b0, r_end} + r_need;
    assign idx_m1  = r_idx - CNT_W'(1);

    ffpa_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_req.req_size),
        .i_divisor  (bs_eff),
        .o_done     (rem_done),
        .o_rem      (rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= BS_W'(1);
            r_end        <= '0;
            r_cnt        <= '0;
            r_idx        <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
            if (i_cfg_we && i_cfg_idx == CFG_BLOCK_SIZE) begin
                r_block_size <= i_cfg_wdata[BS_W-1:0];
            end
            if (i_cfg_we && i_cfg_idx == CFG_START_OFFSET) begin
                r_end <= i_cfg_wdata & SPACE_MAX[FIELD_W-1:0];
            end else if (i_cmd.cut) begin
                r_end <= end_sum[FIELD_W-1:0];
            end
            if (i_cmd.push) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_cmd.cnt_dec) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_req) begin
            r_req <= i_req;
        end
        if (i_cmd.calc_need) begin
            r_need <= {1'b0, r_req.req_size} + (FIELD_W + 1)'(pad);
        end
        if (i_cmd.emit) begin
            r_res.status <= i_cmd.emit_status;
            case (i_cmd.emit_status)
                ST_REUSED: begin
                    r_res.page_offset <= r_rd.offset;
                    r_res.page_size   <= r_rd.size;
                end
                ST_CUT: begin
                    r_res.page_offset <= r_end;
                    r_res.page_size   <= r_need[FIELD_W-1:0];
                end
                default: begin
                    r_res.page_offset <= '0;
                    r_res.page_size   <= '0;
                end
            endcase
        end
    end

    // free list: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_cnt[IDX_W-1:0]] <= {r_req.req_size, r_req.req_offset};
        end else if (i_cmd.shift_wr) begin
            r_mem[idx_m1[IDX_W-1:0]] <= r_rd;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    assign o_sts.func     = r_req.func;
    assign o_sts.div_done = rem_done;
    assign o_sts.need_ovf = r_need > SPACE_MAX;
    assign o_sts.at_end   = r_idx == r_cnt;
    assign o_sts.fit      = {1'b0, r_rd.size} >= r_need;
    assign o_sts.full     = r_cnt == CNT_W'(FREE_ENTRIES);
    assign o_sts.end_ovf  = end_sum > SPACE_MAX;

    assign o_res        = r_res;
    assign o_res_strobe = r_strobe;

endmodule

`default_nettype wire

// ----- rtl/core/ffpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffpa_ctrl
// Controller: sequences rounding, first-fit scan, list compaction and cut.
// ----------------------------------------------------------------------------
`default_nettype none

module ffpa_ctrl
    import ffpa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    output logic      o_busy,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_DIV_WAIT = 4'd2;
    localparam logic [3:0] S_CHECK    = 4'd3;
    localparam logic [3:0] S_SCAN_RD  = 4'd4;
    localparam logic [3:0] S_SCAN_CMP = 4'd5;
    localparam logic [3:0] S_SHIFT_RD = 4'd6;
    localparam logic [3:0] S_SHIFT_WR = 4'd7;
    localparam logic [3:0] S_CUT      = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.ld_req = 1'b1;
                    n_state      = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.func) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.full) begin
                        o_cmd.emit_status = ST_DROPPED;
                    end else begin
                        o_cmd.push        = 1'b1;
                        o_cmd.emit_status = ST_FREED;
                    end
                    n_state = S_IDLE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.calc_need = 1'b1;
                    o_cmd.idx_clr   = 1'b1;
                    n_state         = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.need_ovf) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = ST_EXHAUSTED;
                    n_state           = S_IDLE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_sts.at_end) begin
                    n_state = S_CUT;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                o_cmd.idx_inc = 1'b1;
                if (i_sts.fit) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = ST_REUSED;
                    n_state           = S_SHIFT_RD;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if (i_sts.at_end) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.shift_wr = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = S_SHIFT_RD;
            end
            S_CUT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.end_ovf) begin
                    o_cmd.emit_status = ST_EXHAUSTED;
                end else begin
                    o_cmd.cut         = 1'b1;
                    o_cmd.emit_status = ST_CUT;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = r_state != S_IDLE;

endmodule

`default_nettype wire

// ----- rtl/core/first_fit_page_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_page_allocator
// First-fit page allocator with a free list and an end-of-space pointer.
//
//  channel  | ports                                | handshake
//  ---------+--------------------------------------+---------------------------
//  request  | start, busy, i_req                   | taken when start && !busy
//  result   | o_res_strobe, o_res                  | one cycle, cannot stall
//  config   | i_cfg_we, i_cfg_idx, i_cfg_wdata     | write when i_cfg_we
//
// One request at a time; busy is high from the accepting edge until the
// controller is idle again, and the strobe is registered from the emitting cycle.
// A free pushes the entry or drops it. An allocate first rounds the size in
// the remainder unit, then scans the free list entry by entry; a hit compacts
// the later entries, a miss cuts from the end pointer. Reset is synchronous.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_page_allocator
    import ffpa_pkg::*;
#(
    parameter int FREE_ENTRIES = 16
)
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [FIELD_W-1:0]   i_cfg_wdata,
    input  wire logic                 start,
    output logic                      busy,
    input  wire t_req                 i_req,
    output logic                      o_res_strobe,
    output t_res                      o_res
);

    t_cmd cmd;
    t_sts sts;

    ffpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ffpa_dp #(
        .FREE_ENTRIES (FREE_ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req        (i_req),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_res        (o_res),
        .o_res_strobe (o_res_strobe)
    );

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for the first-fit page allocator. Requests go in over the
// start/busy handshake. A scoreboard follows the free list, the end pointer
// and both registers, and predicts each page result. A checker compares
// every strobed result with the oldest prediction. Traffic is a directed
// corner set, a register sweep, then random phases that recycle live pages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import ffpa_pkg::*;

    localparam int FREE_DEPTH = 16;
    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;
    localparam logic [63:0] TOP_ADDR = 64'(SPACE_MAX);
    localparam logic [FIELD_W-1:0] ALL_ONES = '1;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [FIELD_W-1:0]   i_cfg_wdata = '0;
    logic                 start       = 1'b0;
    logic                 busy;
    t_req                 i_req       = '0;
    logic                 o_res_strobe;
    t_res                 o_res;

    // scoreboard state
    logic [BS_W-1:0]    gran    = BS_W'(1);
    logic [FIELD_W-1:0] end_ptr = '0;
    t_entry             free_list[$];
    t_entry             live_pages[$];
    t_res               pending_results[$];
    t_res               oldest_page;
    int                 fail_count = 0;
    bit                 no_idle    = 1'b0;

    first_fit_page_allocator #(
        .FREE_ENTRIES(FREE_DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_strobe(o_res_strobe),
        .o_res       (o_res)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [FIELD_W-1:0] rand48();
        logic [63:0] t;
        t = {$urandom(), $urandom()};
        return t[FIELD_W-1:0];
    endfunction

    function automatic logic round_need(input logic [63:0] req, output logic [63:0] need);
        logic [63:0] bs;
        logic [63:0] base;
        bs = (gran == '0) ? 64'd1 : 64'(gran);
        base = (req / bs) * bs;
        need = '0;
        if (req % bs != 0) begin
            if (base > TOP_ADDR - bs)
                return 1'b0;
            base += bs;
        end
        need = base;
        return base <= TOP_ADDR;
    endfunction

    function automatic t_res predict_page(input t_req r);
        t_res        res;
        t_entry      ent;
        logic [63:0] need;
        logic        ok;
        int          hit;
        res = '0;
        hit = -1;
        if (r.func == FN_FREE) begin
            if (free_list.size() >= FREE_DEPTH) begin
                res.status = ST_DROPPED;
            end else begin
                ent.size   = r.req_size;
                ent.offset = r.req_offset;
                free_list.push_back(ent);
                res.status = ST_FREED;
            end
            return res;
        end
        ok = round_need(64'(r.req_size), need);
        if (ok) begin
            foreach (free_list[i])
                if (hit < 0 && 64'(free_list[i].size) >= need)
                    hit = i;
        end
        if (ok && hit >= 0) begin
            res.page_offset = free_list[hit].offset;
            res.page_size   = free_list[hit].size;
            res.status      = ST_REUSED;
            free_list.delete(hit);
        end else if (ok && need <= TOP_ADDR - 64'(end_ptr)) begin
            res.page_offset = end_ptr;
            res.page_size   = need[FIELD_W-1:0];
            res.status      = ST_CUT;
            end_ptr         = end_ptr + need[FIELD_W-1:0];
        end else begin
            res.status = ST_EXHAUSTED;
        end
        return res;
    endfunction

    task automatic idle_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            n = 0;
        else if (r < 92)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(10, 60);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_request(input logic fn, input logic [FIELD_W-1:0] size,
                                input logic [FIELD_W-1:0] off);
        t_req   r;
        t_res   res;
        t_entry pg;
        r.func       = fn;
        r.req_size   = size;
        r.req_offset = off;
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        res = predict_page(r);
        pending_results.push_back(res);
        if (fn == FN_ALLOC && res.status != ST_EXHAUSTED) begin
            pg.size   = res.page_size;
            pg.offset = res.page_offset;
            live_pages.push_back(pg);
        end
        idle_gap();
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] data);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_BLOCK_SIZE)
            gran = data[BS_W-1:0];
        else if (idx == CFG_START_OFFSET)
            end_ptr = data;
        @(posedge i_clk);
    endtask

    // zero-size cuts, free list fill and overflow, first-fit reuse, exhaustion
    task automatic test_directed();
        no_idle = 1'b1;
        send_request(FN_ALLOC, '0, ALL_ONES);
        send_request(FN_ALLOC, 48'd100, '0);
        send_request(FN_ALLOC, 48'd1, 48'h5A5A_5A5A_5A5A);
        send_request(FN_FREE, '0, '0);
        send_request(FN_FREE, ALL_ONES, ALL_ONES);
        for (int k = 2; k <= FREE_DEPTH; k++)
            send_request(FN_FREE, 48'(k * 40), 48'h5555_5555_5555 ^ 48'(k << 4));
        send_request(FN_ALLOC, '0, '0);
        send_request(FN_ALLOC, ALL_ONES, '0);
        send_request(FN_ALLOC, 48'd300, ALL_ONES);
        send_request(FN_ALLOC, ALL_ONES, '0);
        send_request(FN_FREE, 48'd64, 48'hAAAA_AAAA_AAAA);
    endtask

    // register extremes, unknown indexes, rounding overflow, top-of-space cuts
    task automatic test_config_sweep();
        no_idle = 1'b0;
        for (int ix = int'(CFG_START_OFFSET) + 1; ix < (1 << CFG_IDX_W); ix++)
            write_reg(CFG_IDX_W'(ix), rand48());
        send_request(FN_ALLOC, 48'd33, '0);

        write_reg(CFG_BLOCK_SIZE, '0);
        send_request(FN_ALLOC, '0, '0);
        send_request(FN_ALLOC, 48'd7, '0);
        send_request(FN_ALLOC, 48'd12345, '0);

        write_reg(CFG_BLOCK_SIZE, 48'd65536);
        write_reg(CFG_START_OFFSET, '0);
        send_request(FN_ALLOC, 48'd1, '0);
        send_request(FN_ALLOC, ALL_ONES, '0);
        send_request(FN_ALLOC, 48'hFFFF_FFFF_0000, '0);
        send_request(FN_ALLOC, 48'd65537, '0);

        write_reg(CFG_BLOCK_SIZE, ALL_ONES);
        send_request(FN_ALLOC, 48'd1, '0);
        send_request(FN_ALLOC, 48'd131071, '0);
        send_request(FN_ALLOC, 48'd131072, '0);

        write_reg(CFG_BLOCK_SIZE, 48'd1);
        write_reg(CFG_START_OFFSET, ALL_ONES);
        send_request(FN_ALLOC, '0, '0);
        send_request(FN_ALLOC, 48'hFFFF_FFFF_FFF0, '0);
        send_request(FN_FREE, 48'd500, 48'd777);
        send_request(FN_ALLOC, ALL_ONES, '0);

        write_reg(CFG_START_OFFSET, ALL_ONES - 48'd1000);
        send_request(FN_ALLOC, 48'd1000, '0);
        send_request(FN_ALLOC, 48'hFFFF_FFFF_FFFE, '0);
        write_reg(CFG_START_OFFSET, '0);
    endtask

    // random phases: mostly recycled pages and small sizes, some raw noise
    task automatic test_random_traffic();
        int                 r;
        int                 n;
        int                 alloc_pct;
        logic [FIELD_W-1:0] bs_val;
        logic [FIELD_W-1:0] so_val;
        logic [FIELD_W-1:0] sz;
        t_entry             pg;
        for (int phase = 0; phase < 11; phase++) begin
            case ($urandom_range(0, 5))
                0: bs_val = 48'd1;
                1: bs_val = 48'd1 << $urandom_range(0, 16);
                2: bs_val = 48'($urandom_range(1, 64));
                3: bs_val = 48'($urandom_range(1, 65536));
                4: bs_val = '0;
                default: bs_val = 48'd65536;
            endcase
            write_reg(CFG_BLOCK_SIZE, bs_val);
            r = $urandom_range(0, 9);
            if (r < 7)
                so_val = 48'($urandom_range(0, 1 << 20));
            else if (r < 9)
                so_val = ALL_ONES - 48'($urandom_range(0, 1 << 24));
            else
                so_val = rand48();
            write_reg(CFG_START_OFFSET, so_val);
            no_idle   = (phase % 4 == 1);
            alloc_pct = $urandom_range(35, 65);
            repeat (160) begin
                r = $urandom_range(0, 99);
                if (r < alloc_pct) begin
                    r = $urandom_range(0, 99);
                    if (r < 85)
                        sz = 48'($urandom_range(0, 8192));
                    else if (r < 95)
                        sz = 48'($urandom_range(0, 1 << 20));
                    else
                        sz = rand48();
                    send_request(FN_ALLOC, sz, rand48());
                end else if (live_pages.size() != 0 && $urandom_range(0, 99) < 80) begin
                    n  = $urandom_range(0, live_pages.size() - 1);
                    pg = live_pages[n];
                    live_pages.delete(n);
                    send_request(FN_FREE, pg.size, pg.offset);
                end else begin
                    sz = $urandom_range(0, 1) ? rand48() : 48'($urandom_range(0, 4096));
                    send_request(FN_FREE, sz, rand48());
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: %h", o_res);
                fail_count++;
            end else begin
                oldest_page = pending_results.pop_front();
                if (o_res.page_offset !== oldest_page.page_offset) begin
                    $error("page_offset expected %h actual %h",
                           oldest_page.page_offset, o_res.page_offset);
                    fail_count++;
                end
                if (o_res.page_size !== oldest_page.page_size) begin
                    $error("page_size expected %h actual %h",
                           oldest_page.page_size, o_res.page_size);
                    fail_count++;
                end
                if (o_res.status !== oldest_page.status) begin
                    $error("status expected %0d actual %0d",
                           oldest_page.status, o_res.status);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_config_sweep();
        test_random_traffic();
        wait_idle();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("tb failed");
        $finish;
    end

endmodule
